// ===== hdl/tie_pkg.sv =====
// shared types and constants of the toy isa execute unit
// opcode values, serial alu operation codes and the alu control/status structs
// no dependencies
package tie_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 5;

  localparam logic [4:0] OP_MOV   = 5'h02;
  localparam logic [4:0] OP_INC   = 5'h07;
  localparam logic [4:0] OP_DEC   = 5'h08;
  localparam logic [4:0] OP_ADD   = 5'h09;
  localparam logic [4:0] OP_SUB   = 5'h0A;
  localparam logic [4:0] OP_MUL   = 5'h0B;
  localparam logic [4:0] OP_DIV   = 5'h0C;
  localparam logic [4:0] OP_NOT   = 5'h0F;
  localparam logic [4:0] OP_XOR   = 5'h10;
  localparam logic [4:0] OP_OR    = 5'h11;
  localparam logic [4:0] OP_AND   = 5'h12;
  localparam logic [4:0] OP_SHL   = 5'h13;
  localparam logic [4:0] OP_SHR   = 5'h14;
  localparam logic [4:0] OP_CMP   = 5'h15;
  localparam logic [4:0] OP_CALL  = 5'h16;
  localparam logic [4:0] OP_JE    = 5'h19;
  localparam logic [4:0] OP_JNE   = 5'h1A;
  localparam logic [4:0] OP_JG    = 5'h1B;
  localparam logic [4:0] OP_JGE   = 5'h1C;
  localparam logic [4:0] OP_JL    = 5'h1D;
  localparam logic [4:0] OP_JLE   = 5'h1E;
  localparam logic [4:0] OP_PRINT = 5'h1F;

  typedef enum logic [3:0] {
    ALU_PASS,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_NOT,
    ALU_CMP,
    ALU_MUL,
    ALU_DIV,
    ALU_SHL,
    ALU_SHR
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic gt;
  } alu_stat_t;

endpackage

// ===== hdl/tie_regfile.sv =====
// register file of the execute unit with per-entry valid bits
// two registered read ports, one write port; depends on tie_pkg
module tie_regfile
  import tie_pkg::*;
#(
  parameter int NUM_REGISTERS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_a_addr,
  input  logic [IDX_W-1:0]  rd_b_addr,
  output logic [DATA_W-1:0] rd_a_data,
  output logic [DATA_W-1:0] rd_b_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int AW = $clog2(NUM_REGISTERS);

  logic [DATA_W-1:0]        mem [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] vld_r;
  logic [DATA_W-1:0]        rd_a_r;
  logic [DATA_W-1:0]        rd_b_r;
  logic                     a_ok;
  logic                     b_ok;
  logic                     w_ok;

  // indexes past the last register read as zero and ignore writes
  assign a_ok = {1'b0, rd_a_addr} < (IDX_W+1)'(NUM_REGISTERS);
  assign b_ok = {1'b0, rd_b_addr} < (IDX_W+1)'(NUM_REGISTERS);
  assign w_ok = {1'b0, wr_addr} < (IDX_W+1)'(NUM_REGISTERS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en && w_ok) begin
      vld_r[wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && w_ok) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= (a_ok && vld_r[rd_a_addr[AW-1:0]]) ? mem[rd_a_addr[AW-1:0]] : '0;
      rd_b_r <= (b_ok && vld_r[rd_b_addr[AW-1:0]]) ? mem[rd_b_addr[AW-1:0]] : '0;
    end
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

// ===== hdl/tie_alu.sv =====
// serial alu: bit-serial add/sub/logic/compare, shift-add multiply,
// restoring divide and one-bit-per-cycle shifts; depends on tie_pkg
module tie_alu
  import tie_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  alu_cmd_t          cmd_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output alu_stat_t         stat_o,
  output logic [DATA_W-1:0] res_o
);

  typedef enum logic [3:0] {
    AS_IDLE = 4'b0001,
    AS_RUN  = 4'b0010,
    AS_FIX  = 4'b0100,
    AS_DONE = 4'b1000
  } alu_st_t;

  alu_st_t           st_r, st_nxt;
  alu_op_t           op_r;
  logic [DATA_W-1:0] x_r;
  logic [DATA_W-1:0] y_r;
  logic [DATA_W-1:0] acc_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              cy_r;
  logic              eq_r;
  logic              gt_r;
  logic              neg_r;

  logic              abit, bbit, beff, sbit, cout;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] madd;
  logic [DATA_W-1:0] a_mag, b_mag;
  logic              is_shift_in;

  assign abit  = x_r[0];
  assign bbit  = y_r[0];
  assign beff  = (op_r == ALU_SUB) ? ~bbit : bbit;
  assign cout  = (abit & beff) | (cy_r & (abit ^ beff));
  assign trial = {acc_r, x_r[DATA_W-1]} - {1'b0, y_r};
  assign madd  = acc_r + (y_r[0] ? x_r : '0);
  assign a_mag = a_i[DATA_W-1] ? (DATA_W'(0) - a_i) : a_i;
  assign b_mag = b_i[DATA_W-1] ? (DATA_W'(0) - b_i) : b_i;
  assign is_shift_in = (cmd_i.op == ALU_SHL) || (cmd_i.op == ALU_SHR);

  always_comb begin
    case (op_r)
      ALU_ADD, ALU_SUB: sbit = abit ^ beff ^ cy_r;
      ALU_AND:          sbit = abit & bbit;
      ALU_OR:           sbit = abit | bbit;
      ALU_XOR:          sbit = abit ^ bbit;
      ALU_NOT:          sbit = ~abit;
      ALU_PASS:         sbit = bbit;
      default:          sbit = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      AS_IDLE: begin
        if (cmd_i.start) begin
          // a zero shift amount has nothing to iterate
          if (is_shift_in && (b_i[CNT_W-1:0] == '0)) st_nxt = AS_DONE;
          else                                      st_nxt = AS_RUN;
        end
      end
      AS_RUN: begin
        if (cnt_r == '0) st_nxt = (op_r == ALU_DIV) ? AS_FIX : AS_DONE;
      end
      AS_FIX:  st_nxt = AS_DONE;
      AS_DONE: st_nxt = AS_IDLE;
      default: st_nxt = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= AS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == AS_IDLE && cmd_i.start) begin
      op_r  <= cmd_i.op;
      cy_r  <= (cmd_i.op == ALU_SUB);
      eq_r  <= 1'b1;
      gt_r  <= 1'b0;
      acc_r <= '0;
      neg_r <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
      if (cmd_i.op == ALU_DIV) begin
        x_r <= a_mag;
        y_r <= b_mag;
      end else begin
        x_r <= a_i;
        y_r <= b_i;
      end
      if (is_shift_in) cnt_r <= b_i[CNT_W-1:0] - CNT_W'(1);
      else             cnt_r <= CNT_W'(DATA_W - 1);
    end else if (st_r == AS_RUN) begin
      cnt_r <= cnt_r - CNT_W'(1);
      case (op_r)
        ALU_MUL: begin
          acc_r <= madd;
          x_r   <= {x_r[DATA_W-2:0], 1'b0};
          y_r   <= {1'b0, y_r[DATA_W-1:1]};
        end
        ALU_DIV: begin
          // remainder takes the next dividend bit, quotient bit shifts into x
          if (!trial[DATA_W]) begin
            acc_r <= trial[DATA_W-1:0];
            x_r   <= {x_r[DATA_W-2:0], 1'b1};
          end else begin
            acc_r <= {acc_r[DATA_W-2:0], x_r[DATA_W-1]};
            x_r   <= {x_r[DATA_W-2:0], 1'b0};
          end
        end
        ALU_SHL: x_r <= {x_r[DATA_W-2:0], 1'b0};
        ALU_SHR: x_r <= {x_r[DATA_W-1], x_r[DATA_W-1:1]};
        default: begin
          x_r   <= {1'b0, x_r[DATA_W-1:1]};
          y_r   <= {1'b0, y_r[DATA_W-1:1]};
          acc_r <= {sbit, acc_r[DATA_W-1:1]};
          cy_r  <= cout;
          eq_r  <= eq_r & (abit == bbit);
          // highest differing bit decides, sign bit counts inverted
          if (abit != bbit) gt_r <= (cnt_r == '0) ? bbit : abit;
        end
      endcase
    end else if (st_r == AS_FIX) begin
      acc_r <= neg_r ? (DATA_W'(0) - x_r) : x_r;
    end
  end

  assign res_o       = ((op_r == ALU_SHL) || (op_r == ALU_SHR)) ? x_r : acc_r;
  assign stat_o.done = (st_r == AS_DONE);
  assign stat_o.eq   = eq_r;
  assign stat_o.gt   = gt_r;

endmodule

// ===== hdl/toy_isa_execute_unit_core.sv =====
// toy isa execute unit: one instruction per transaction, one result per transaction
// nop, jumps, call, print and divide by zero skip the alu; the other ops run in the serial
// alu, and divide adds a sign fix-up step after it
// one instruction at a time: next accept the cycle after the result loads, with the serial
// alu running 32 bit steps for most ops; sync active-low reset clears regs, flags and pc
// depends on tie_pkg, tie_regfile, tie_alu
module toy_isa_execute_unit_core
  import tie_pkg::*;
#(
  parameter int NUM_REGISTERS = 32,
  parameter int PC_BITS       = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_opcode,
  input  logic [7:0]         in_dest_or_target,
  input  logic               in_immediate_flag,
  input  logic signed [31:0] in_source_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_next_pc,
  output logic               out_print_valid,
  output logic signed [31:0] out_print_value,
  output logic               out_divide_error
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_WB   = 4'b1000
  } st_t;

  st_t               st_r, st_nxt;
  logic [4:0]        op_r;
  logic [7:0]        dst_r;
  logic              immf_r;
  logic [DATA_W-1:0] imm_r;
  logic [PC_BITS-1:0] pc_r;
  logic [PC_BITS-1:0] npc_r;
  logic [1:0]        flags_r;
  logic              pv_r;
  logic [DATA_W-1:0] pval_r;
  logic              derr_r;

  logic              out_valid_r;
  logic [7:0]        out_pc_r;
  logic              out_pv_r;
  logic [DATA_W-1:0] out_pval_r;
  logic              out_derr_r;

  logic              accept;
  logic              out_load;
  logic [DATA_W-1:0] rd_d, rd_s, src;
  alu_cmd_t          alu_cmd;
  alu_stat_t         alu_stat;
  logic [DATA_W-1:0] alu_b, alu_res;
  logic              use_alu, take, is_call, is_print, div0;
  logic [PC_BITS-1:0] npc;
  logic              wr_en;

  assign accept   = in_valid && (st_r == ST_IDLE);
  assign in_stall = (st_r != ST_IDLE);
  assign out_load = (st_r == ST_WB) && (!out_valid_r || !out_stall);
  assign src      = immf_r ? imm_r : rd_s;

  tie_regfile #(
    .NUM_REGISTERS(NUM_REGISTERS)
  ) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_a_addr (in_dest_or_target[IDX_W-1:0]),
    .rd_b_addr (in_source_value[IDX_W-1:0]),
    .rd_a_data (rd_d),
    .rd_b_data (rd_s),
    .wr_en     (wr_en),
    .wr_addr   (dst_r[IDX_W-1:0]),
    .wr_data   (alu_res)
  );

  tie_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (alu_cmd),
    .a_i    (rd_d),
    .b_i    (alu_b),
    .stat_o (alu_stat),
    .res_o  (alu_res)
  );

  // instruction decode, evaluated while the operands sit in the read registers
  always_comb begin
    use_alu  = 1'b0;
    alu_cmd.op = ALU_PASS;
    alu_b    = src;
    take     = 1'b0;
    is_call  = 1'b0;
    is_print = 1'b0;
    div0     = 1'b0;
    unique case (op_r) inside
      OP_MOV: begin use_alu = 1'b1; alu_cmd.op = ALU_PASS; end
      OP_INC: begin use_alu = 1'b1; alu_cmd.op = ALU_ADD; alu_b = DATA_W'(1); end
      OP_DEC: begin use_alu = 1'b1; alu_cmd.op = ALU_SUB; alu_b = DATA_W'(1); end
      OP_ADD: begin use_alu = 1'b1; alu_cmd.op = ALU_ADD; end
      OP_SUB: begin use_alu = 1'b1; alu_cmd.op = ALU_SUB; end
      OP_MUL: begin use_alu = 1'b1; alu_cmd.op = ALU_MUL; end
      OP_DIV: begin
        alu_cmd.op = ALU_DIV;
        if (src == '0) div0    = 1'b1;
        else           use_alu = 1'b1;
      end
      OP_NOT: begin use_alu = 1'b1; alu_cmd.op = ALU_NOT; end
      OP_XOR: begin use_alu = 1'b1; alu_cmd.op = ALU_XOR; end
      OP_OR:  begin use_alu = 1'b1; alu_cmd.op = ALU_OR; end
      OP_AND: begin use_alu = 1'b1; alu_cmd.op = ALU_AND; end
      OP_SHL: begin use_alu = 1'b1; alu_cmd.op = ALU_SHL; end
      OP_SHR: begin use_alu = 1'b1; alu_cmd.op = ALU_SHR; end
      OP_CMP: begin use_alu = 1'b1; alu_cmd.op = ALU_CMP; end
      OP_CALL:  is_call = 1'b1;
      OP_JE:    take = flags_r[0];
      OP_JNE:   take = !flags_r[0];
      OP_JG:    take = flags_r[1];
      OP_JGE:   take = flags_r[0] || flags_r[1];
      OP_JL:    take = !flags_r[0] && !flags_r[1];
      OP_JLE:   take = !flags_r[1];
      OP_PRINT: is_print = 1'b1;
      default: ;
    endcase
    alu_cmd.start = (st_r == ST_READ) && use_alu;
  end

  always_comb begin
    if (is_call)   npc = rd_d[PC_BITS-1:0];
    else if (take) npc = PC_BITS'(dst_r);
    else           npc = pc_r + PC_BITS'(1);
  end

  assign wr_en = (st_r == ST_EXEC) && alu_stat.done && (op_r != OP_CMP);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept)        st_nxt = ST_READ;
      ST_READ: st_nxt = use_alu ? ST_EXEC : ST_WB;
      ST_EXEC: if (alu_stat.done) st_nxt = ST_WB;
      ST_WB:   if (out_load)      st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pc_r        <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        pc_r        <= npc_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == ST_EXEC && alu_stat.done && op_r == OP_CMP) begin
        flags_r <= {alu_stat.gt, alu_stat.eq};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      dst_r  <= in_dest_or_target;
      immf_r <= in_immediate_flag;
      imm_r  <= in_source_value;
    end
    if (st_r == ST_READ) begin
      npc_r  <= npc;
      pv_r   <= is_print;
      pval_r <= is_print ? rd_d : '0;
      derr_r <= div0;
    end
    if (out_load) begin
      out_pc_r   <= 8'(npc_r);
      out_pv_r   <= pv_r;
      out_pval_r <= pval_r;
      out_derr_r <= derr_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_pc_r;
  assign out_print_valid  = out_pv_r;
  assign out_print_value  = out_pval_r;
  assign out_divide_error = out_derr_r;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for toy_isa_execute_unit_core: directed and random instructions
// predicts every result from an architectural model kept here; depends on tie_pkg and the rtl
module tb_top;
  import tie_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam logic [4:0] OP_NOP = 5'h00;

  typedef struct {
    logic [4:0]  op;
    logic [7:0]  dst;
    logic        imm_flag;
    logic [31:0] src;
  } instr_t;

  typedef struct {
    logic [7:0]  next_pc;
    logic        print_valid;
    logic [31:0] print_value;
    logic        divide_error;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] in_opcode = '0;
  logic [7:0] in_dest_or_target = '0;
  logic in_immediate_flag = 1'b0;
  logic signed [31:0] in_source_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_next_pc;
  logic out_print_valid;
  logic signed [31:0] out_print_value;
  logic out_divide_error;

  instr_t pending_instrs[$];
  result_t predicted_results[$];

  // architectural state seen by the instruction stream
  logic [31:0] arch_regs [32];
  logic [1:0]  arch_flags = '0;
  logic [7:0]  arch_pc = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  logic [4:0] alu_ops [13] = '{OP_MOV, OP_INC, OP_DEC, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                              OP_NOT, OP_XOR, OP_OR, OP_AND, OP_SHL, OP_SHR};
  logic [4:0] jump_ops [6] = '{OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE};

  toy_isa_execute_unit_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_dest_or_target (in_dest_or_target),
    .in_immediate_flag (in_immediate_flag),
    .in_source_value   (in_source_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_next_pc       (out_next_pc),
    .out_print_valid   (out_print_valid),
    .out_print_value   (out_print_value),
    .out_divide_error  (out_divide_error)
  );

  always #4 clk = ~clk;

  function automatic result_t execute_instr(instr_t t);
    result_t r;
    logic [31:0] d, s, mag_a, mag_b, q;
    logic [7:0] nxt;
    logic taken;
    d = arch_regs[t.dst[4:0]];
    s = t.imm_flag ? t.src : arch_regs[t.src[4:0]];
    nxt = arch_pc + 8'd1;
    taken = 1'b0;
    r.next_pc = '0;
    r.print_valid = 1'b0;
    r.print_value = '0;
    r.divide_error = 1'b0;
    case (t.op)
      OP_MOV: arch_regs[t.dst[4:0]] = s;
      OP_INC: arch_regs[t.dst[4:0]] = d + 32'd1;
      OP_DEC: arch_regs[t.dst[4:0]] = d - 32'd1;
      OP_ADD: arch_regs[t.dst[4:0]] = d + s;
      OP_SUB: arch_regs[t.dst[4:0]] = d - s;
      OP_MUL: arch_regs[t.dst[4:0]] = d * s;
      OP_DIV: begin
        if (s == '0) begin
          r.divide_error = 1'b1;
        end else begin
          // magnitudes then sign fix-up, so min-int over minus one wraps
          mag_a = d[31] ? -d : d;
          mag_b = s[31] ? -s : s;
          q = mag_a / mag_b;
          if (d[31] ^ s[31]) q = -q;
          arch_regs[t.dst[4:0]] = q;
        end
      end
      OP_NOT: arch_regs[t.dst[4:0]] = ~d;
      OP_XOR: arch_regs[t.dst[4:0]] = d ^ s;
      OP_OR:  arch_regs[t.dst[4:0]] = d | s;
      OP_AND: arch_regs[t.dst[4:0]] = d & s;
      OP_SHL: arch_regs[t.dst[4:0]] = d << s[4:0];
      OP_SHR: arch_regs[t.dst[4:0]] = $signed(d) >>> s[4:0];
      OP_CMP: arch_flags = {$signed(d) > $signed(s), d == s};
      OP_CALL: nxt = d[7:0];
      OP_JE:  taken = arch_flags[0];
      OP_JNE: taken = !arch_flags[0];
      OP_JG:  taken = arch_flags[1];
      OP_JGE: taken = |arch_flags;
      OP_JL:  taken = (arch_flags == 2'b00);
      OP_JLE: taken = !arch_flags[1];
      OP_PRINT: begin
        r.print_valid = 1'b1;
        r.print_value = d;
      end
      default: ;
    endcase
    if (taken) nxt = t.dst;
    arch_pc = nxt;
    r.next_pc = nxt;
    return r;
  endfunction

  task automatic add_instr(logic [4:0] op, logic [7:0] dst, logic imm_flag, logic [31:0] src);
    instr_t t;
    t.op = op;
    t.dst = dst;
    t.imm_flag = imm_flag;
    t.src = src;
    pending_instrs.push_back(t);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // register sources use a fully random word, only the low 5 bits select
  function automatic logic [31:0] rand_src(logic imm_flag);
    return imm_flag ? rand_word() : $urandom;
  endfunction

  task automatic queue_random(int n);
    int count;
    int pick;
    int jumps;
    logic f;
    count = 0;
    while (count < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        f = ($urandom_range(0, 4) != 0);
        add_instr(OP_MOV, 8'($urandom), f, rand_src(f));
        count++;
      end else if (pick < 30) begin
        // compare followed by conditional branches on the fresh flags
        f = 1'($urandom_range(0, 1));
        add_instr(OP_CMP, 8'($urandom), f, rand_src(f));
        jumps = $urandom_range(1, 2);
        repeat (jumps) add_instr(jump_ops[$urandom_range(0, 5)], 8'($urandom),
                                 1'($urandom), $urandom);
        count += 1 + jumps;
      end else if (pick < 36) begin
        // divide corner cases: zero and minus one immediate divisors, else a register divisor
        f = 1'($urandom_range(0, 1));
        add_instr(OP_DIV, 8'($urandom), f,
                  f ? ($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF) : $urandom);
        count++;
      end else if (pick < 42) begin
        add_instr($urandom_range(0, 1) ? OP_CALL : OP_PRINT, 8'($urandom), 1'($urandom),
                  $urandom);
        count++;
      end else if (pick < 47) begin
        add_instr(5'($urandom), 8'($urandom), 1'($urandom), $urandom);
        count++;
      end else begin
        f = 1'($urandom_range(0, 1));
        add_instr(alu_ops[$urandom_range(0, 12)], 8'($urandom), f, rand_src(f));
        count++;
      end
    end
  endtask

  task automatic drain();
    while (pending_instrs.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  // driver: holds a transaction while stalled, otherwise may insert idle cycles
  always @(posedge clk) begin : driver
    instr_t nxt;
    instr_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.op = in_opcode;
        cur.dst = in_dest_or_target;
        cur.imm_flag = in_immediate_flag;
        cur.src = in_source_value;
        predicted_results.push_back(execute_instr(cur));
      end
      if (!in_valid || !in_stall) begin
        if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_instrs.pop_front();
          in_valid <= 1'b1;
          in_opcode <= nxt.op;
          in_dest_or_target <= nxt.dst;
          in_immediate_flag <= nxt.imm_flag;
          in_source_value <= nxt.src;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $error("result transaction with nothing predicted, next_pc %0h", out_next_pc);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        if (out_next_pc !== want.next_pc) begin
          $error("next_pc expected %0h actual %0h", want.next_pc, out_next_pc);
          fail_count++;
        end
        if (out_print_valid !== want.print_valid) begin
          $error("print_valid expected %0b actual %0b", want.print_valid, out_print_valid);
          fail_count++;
        end
        if (out_print_value !== want.print_value) begin
          $error("print_value expected %0h actual %0h", want.print_value, out_print_value);
          fail_count++;
        end
        if (out_divide_error !== want.divide_error) begin
          $error("divide_error expected %0b actual %0b", want.divide_error, out_divide_error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every operation, divide and wrap corner cases
    add_instr(OP_MOV, 8'h01, 1'b1, 32'h7FFF_FFFF);
    add_instr(OP_MOV, 8'hE2, 1'b1, 32'h8000_0000);
    add_instr(OP_MOV, 8'h03, 1'b1, 32'hFFFF_FFFF);
    add_instr(OP_INC, 8'h21, 1'b0, 32'h0);
    add_instr(OP_DEC, 8'h00, 1'b1, 32'h0);
    add_instr(OP_DIV, 8'h02, 1'b0, 32'hFFFF_FFE3);
    add_instr(OP_DIV, 8'h01, 1'b1, 32'h0);
    add_instr(OP_ADD, 8'h03, 1'b0, 32'h0000_0002);
    add_instr(OP_SUB, 8'h04, 1'b1, 32'h8000_0000);
    add_instr(OP_MUL, 8'h02, 1'b0, 32'h0000_0003);
    add_instr(OP_NOT, 8'h05, 1'b1, 32'h0);
    add_instr(OP_XOR, 8'h05, 1'b1, 32'hA5A5_A5A5);
    add_instr(OP_OR,  8'h06, 1'b0, 32'h0000_0005);
    add_instr(OP_AND, 8'h06, 1'b1, 32'h0F0F_0F0F);
    add_instr(OP_SHL, 8'h03, 1'b1, 32'h0000_0021);
    add_instr(OP_SHR, 8'h02, 1'b1, 32'h0000_001F);
    add_instr(OP_CMP, 8'h01, 1'b0, 32'hFFFF_FFE1);
    add_instr(OP_JE,  8'hFF, 1'b0, 32'h0);
    add_instr(OP_CMP, 8'h07, 1'b1, 32'hFFFF_FFFB);
    add_instr(OP_JG,  8'h80, 1'b1, 32'h0);
    add_instr(OP_JGE, 8'h40, 1'b0, 32'h0);
    add_instr(OP_JL,  8'h20, 1'b0, 32'h0);
    add_instr(OP_JLE, 8'h00, 1'b0, 32'h0);
    add_instr(OP_JNE, 8'h10, 1'b0, 32'h0);
    add_instr(OP_CALL, 8'h03, 1'b0, 32'h0);
    add_instr(OP_PRINT, 8'hE2, 1'b1, 32'hFFFF_FFFF);
    add_instr(OP_NOP, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    drain();

    // no idling, with a long receiver hold-off so the input backs up
    queue_random(400);
    hold_req = 1'b1;
    drain();

    send_idle_pct = 62;
    queue_random(400);
    drain();

    send_idle_pct = 0;
    stall_pct = 62;
    queue_random(400);
    drain();

    send_idle_pct = 33;
    stall_pct = 33;
    queue_random(450);
    drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tie_pkg.sv
hdl/tie_regfile.sv
hdl/tie_alu.sv
hdl/toy_isa_execute_unit_core.sv
dv/tb_top.sv
